@@ hdl/vector_norm_limit_projection_macros.svh @@
// Assertion macros shared by the vector norm limit projection RTL.
`ifndef VECTOR_NORM_LIMIT_PROJECTION_MACROS_SVH
`define VECTOR_NORM_LIMIT_PROJECTION_MACROS_SVH

// same-cycle implication
`define VNLP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VNLP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/vnlp_pkg.sv @@
`timescale 1ns / 1ps
package vnlp_pkg;

  localparam int FRAC = 16;
  localparam int SCALE_W = FRAC + 1;

  localparam logic [1:0] REG_CLIP_MODE   = 2'd0;
  localparam logic [1:0] REG_LIMIT       = 2'd1;
  localparam logic [1:0] REG_CHECK_LIMIT = 2'd2;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

@@ hdl/vector_norm_limit_projection.sv @@
`timescale 1ns / 1ps
// Channel   Ports                              Handshake
// input     in_comp_x/y/z                      in_valid / in_ready
// result    out_proj_x/y/z, out_violation      out_valid / out_ready
// config    psel penable pwrite paddr pwdata   pready tied high
//
// One transaction per cycle sustained while the output is not stalled; stages:
// 3 front stages, SAMPLE_BITS+1 square-root stages, 18 divider stages,
// multiply and output stages.
// Synchronous active-low reset clears valid bits and config registers.
// One pipeline enable: all stages hold while the output register is full and
// out_ready is low; in_ready follows that enable.
`include "vector_norm_limit_projection_macros.svh"
module vector_norm_limit_projection #(
  parameter int AXES        = 3,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_comp_x,
  input  logic signed [SAMPLE_BITS-1:0] in_comp_y,
  input  logic signed [SAMPLE_BITS-1:0] in_comp_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_proj_x,
  output logic signed [SAMPLE_BITS-1:0] out_proj_y,
  output logic signed [SAMPLE_BITS-1:0] out_proj_z,
  output logic                          out_violation,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int S   = SAMPLE_BITS;
  localparam int LW  = S - 1;
  localparam int SQW = 2 * S;
  localparam int QW  = vnlp_pkg::SCALE_W;
  localparam int FR  = vnlp_pkg::FRAC;
  localparam int PW  = S + QW;

  typedef struct packed {
    logic [2:0][S-1:0] comp;
    logic [2:0][S-1:0] clip;
    logic              viol;
    logic              sel;
    logic              need;
  } side_t;

  localparam int SW = $bits(side_t);

  // config
  logic          clip_mode_r;
  logic [LW-1:0] limit_r;
  logic [LW-1:0] check_limit_r;
  logic [SQW-1:0] lim_sq_r;
  logic [SQW-1:0] chk_sq_r;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_mode_r   <= 1'b0;
      limit_r       <= '0;
      check_limit_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        vnlp_pkg::REG_CLIP_MODE:   clip_mode_r   <= pwdata[0];
        vnlp_pkg::REG_LIMIT:       limit_r       <= pwdata[LW-1:0];
        vnlp_pkg::REG_CHECK_LIMIT: check_limit_r <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      vnlp_pkg::REG_CLIP_MODE:   prdata = 32'(clip_mode_r);
      vnlp_pkg::REG_LIMIT:       prdata = 32'(limit_r);
      vnlp_pkg::REG_CHECK_LIMIT: prdata = 32'(check_limit_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    lim_sq_r <= SQW'(limit_r) * SQW'(limit_r);
    chk_sq_r <= SQW'(check_limit_r) * SQW'(check_limit_r);
  end

  // pipeline enable
  logic out_valid_r;
  logic en;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 0: input register
  logic [2:0][S-1:0] in_c;
  logic [2:0][S-1:0] c0_r;
  logic              vld0_r;

  assign in_c[0] = (AXES > 0) ? in_comp_x : '0;
  assign in_c[1] = (AXES > 1) ? in_comp_y : '0;
  assign in_c[2] = (AXES > 2) ? in_comp_z : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r <= in_c;
    end
  end

  // stage 1: clamp and squares
  logic signed [S-1:0] lim_s;
  logic signed [S-1:0] chk_s;
  logic [2:0][S-1:0]   clip_v;
  logic [2:0][S-1:0]   mag0;
  logic [2:0]          over_v;
  logic [2:0][S-1:0]   c1_r;
  logic [2:0][S-1:0]   clip1_r;
  logic [2:0][SQW-1:0] sq1_r;
  logic                vclip1_r;
  logic                vld1_r;

  assign lim_s = $signed({1'b0, limit_r});
  assign chk_s = $signed({1'b0, check_limit_r});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if ($signed(c0_r[i]) < -lim_s) begin
        clip_v[i] = -lim_s;
      end else if ($signed(c0_r[i]) > lim_s) begin
        clip_v[i] = lim_s;
      end else begin
        clip_v[i] = c0_r[i];
      end
      over_v[i] = ($signed(c0_r[i]) > chk_s) || ($signed(c0_r[i]) < -chk_s);
      mag0[i]   = c0_r[i][S-1] ? (~c0_r[i] + 1'b1) : c0_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r     <= c0_r;
      clip1_r  <= clip_v;
      vclip1_r <= |over_v;
      for (int i = 0; i < 3; i++) begin
        sq1_r[i] <= SQW'(mag0[i]) * SQW'(mag0[i]);
      end
    end
  end

  // stage 2: sum of squares and compares
  logic [SQW-1:0] sumsq;
  logic [SQW-1:0] sum2_r;
  side_t          side2_r;
  logic           vld2_r;

  assign sumsq = sq1_r[0] + sq1_r[1] + sq1_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum2_r       <= sumsq;
      side2_r.comp <= c1_r;
      side2_r.clip <= clip1_r;
      side2_r.sel  <= clip_mode_r;
      side2_r.viol <= clip_mode_r ? vclip1_r : (sumsq > chk_sq_r);
      side2_r.need <= (sumsq > lim_sq_r);
    end
  end

  // square root and scale divide
  vnlp_pkg::pipe_ctl_t sq_ctl;
  vnlp_pkg::pipe_ctl_t dv_ctl;
  logic [S-1:0]        root;
  logic [SW-1:0]       side_sq;
  logic                vld_sq;
  logic [QW-1:0]       scale;
  logic [SW-1:0]       side_dv;
  logic                vld_dv;

  assign sq_ctl.en  = en;
  assign sq_ctl.vld = vld2_r;
  assign dv_ctl.en  = en;
  assign dv_ctl.vld = vld_sq;

  vnlp_isqrt #(
    .RW (S),
    .SW (SW)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (sq_ctl),
    .rad_i  (sum2_r),
    .side_i (side2_r),
    .root_o (root),
    .side_o (side_sq),
    .vld_o  (vld_sq)
  );

  vnlp_div #(
    .DW (LW + FR),
    .VW (S),
    .QW (QW),
    .SW (SW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (dv_ctl),
    .dvd_i  ({limit_r, FR'(0)}),
    .dvs_i  (root),
    .side_i (side_sq),
    .quo_o  (scale),
    .side_o (side_dv),
    .vld_o  (vld_dv)
  );

  // stage 3: scale magnitudes
  side_t             sd3;
  logic [2:0][S-1:0] mag3;
  logic [2:0][PW-1:0] prod;
  logic [2:0][S-1:0] m3_r;
  logic [2:0][S-1:0] mag3_r;
  side_t             side3_r;
  logic              vld3_r;

  assign sd3 = side_t'(side_dv);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag3[i] = sd3.comp[i][S-1] ? (~sd3.comp[i] + 1'b1) : sd3.comp[i];
      prod[i] = PW'(mag3[i]) * PW'(scale);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld_dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= sd3;
      mag3_r  <= mag3;
      for (int i = 0; i < 3; i++) begin
        m3_r[i] <= prod[i][FR +: S];
      end
    end
  end

  // stage 4: output register
  logic [2:0][S-1:0] proj_v;
  logic [2:0][S-1:0] proj_r;
  logic              viol_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side3_r.sel) begin
        proj_v[i] = side3_r.clip[i];
      end else if (side3_r.need) begin
        proj_v[i] = side3_r.comp[i][S-1] ? (~m3_r[i] + 1'b1) : m3_r[i];
      end else begin
        proj_v[i] = side3_r.comp[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj_r <= proj_v;
      viol_r <= side3_r.viol;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_proj_x    = proj_r[0];
  assign out_proj_y    = proj_r[1];
  assign out_proj_z    = proj_r[2];
  assign out_violation = viol_r;

  `VNLP_ASSERT_IMP(a_scale_shrinks, clk, rst_n, vld3_r && side3_r.need && !side3_r.sel, m3_r[0] <= mag3_r[0], "scaled magnitude grew")

endmodule

@@ hdl/vnlp_isqrt.sv @@
`timescale 1ns / 1ps
`include "vector_norm_limit_projection_macros.svh"
module vnlp_isqrt #(
  parameter int RW = 24,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vnlp_pkg::pipe_ctl_t ctl_i,
  input  logic [2*RW-1:0]     rad_i,
  input  logic [SW-1:0]       side_i,
  output logic [RW-1:0]       root_o,
  output logic [SW-1:0]       side_o,
  output logic                vld_o
);

  logic [2*RW-1:0] rad_r  [RW+1];
  logic [RW+1:0]   rem_r  [RW+1];
  logic [RW-1:0]   root_r [RW+1];
  logic [SW-1:0]   side_r [RW+1];
  logic            vld_r  [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r[0] <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      rad_r[0]  <= rad_i;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= side_i;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW+1:0] rem_t;
    logic [RW+1:0] trial;
    logic          ge;

    assign rem_t = {rem_r[k][RW-1:0], rad_r[k][2*RW-1 -: 2]};
    assign trial = {root_r[k], 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        rad_r[k+1]  <= {rad_r[k][2*RW-3:0], 2'b00};
        rem_r[k+1]  <= ge ? (rem_t - trial) : rem_t;
        root_r[k+1] <= {root_r[k][RW-2:0], ge};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign root_o = root_r[RW];
  assign side_o = side_r[RW];
  assign vld_o  = vld_r[RW];

  `VNLP_ASSERT_IMP(a_rem_bound, clk, rst_n, vld_o, rem_r[RW] <= {1'b0, root_o, 1'b0}, "isqrt remainder above 2*root")
  `VNLP_ASSERT_NXT(a_stall_hold, clk, rst_n, !ctl_i.en, $stable(vld_o) && $stable(root_o), "isqrt moved during stall")

endmodule

@@ hdl/vnlp_div.sv @@
`timescale 1ns / 1ps
`include "vector_norm_limit_projection_macros.svh"
module vnlp_div #(
  parameter int DW = 39,
  parameter int VW = 24,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vnlp_pkg::pipe_ctl_t ctl_i,
  input  logic [DW-1:0]       dvd_i,
  input  logic [VW-1:0]       dvs_i,
  input  logic [SW-1:0]       side_i,
  output logic [QW-1:0]       quo_o,
  output logic [SW-1:0]       side_o,
  output logic                vld_o
);

  localparam int RMW = VW + 1;

  logic [RMW-1:0] rem_r  [QW+1];
  logic [QW-1:0]  low_r  [QW+1];
  logic [VW-1:0]  dvs_r  [QW+1];
  logic [QW-1:0]  quo_r  [QW+1];
  logic [SW-1:0]  side_r [QW+1];
  logic           vld_r  [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r[0] <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      rem_r[0]  <= RMW'(dvd_i[DW-1:QW]);
      low_r[0]  <= dvd_i[QW-1:0];
      dvs_r[0]  <= dvs_i;
      quo_r[0]  <= '0;
      side_r[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RMW-1:0] rem_t;
    logic           ge;

    assign rem_t = {rem_r[k][VW-1:0], low_r[k][QW-1]};
    assign ge    = (rem_t >= {1'b0, dvs_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        rem_r[k+1]  <= ge ? (rem_t - {1'b0, dvs_r[k]}) : rem_t;
        low_r[k+1]  <= {low_r[k][QW-2:0], 1'b0};
        dvs_r[k+1]  <= dvs_r[k];
        quo_r[k+1]  <= {quo_r[k][QW-2:0], ge};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign quo_o  = quo_r[QW];
  assign side_o = side_r[QW];
  assign vld_o  = vld_r[QW];

  `VNLP_ASSERT_NXT(a_stall_hold, clk, rst_n, !ctl_i.en, $stable(vld_o) && $stable(quo_o), "divider moved during stall")

endmodule

@@ tb/vnlp_checker.sv @@
`timescale 1ns / 1ps
module vnlp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [23:0] in_comp_x,
  input  logic signed [23:0] in_comp_y,
  input  logic signed [23:0] in_comp_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [23:0] out_proj_x,
  input  logic signed [23:0] out_proj_y,
  input  logic signed [23:0] out_proj_z,
  input  logic               out_violation,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               viol;
  } proj_t;

  logic        mode_clip;
  logic [22:0] lim;
  logic [22:0] chk_lim;
  proj_t       proj_q[$];

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint scale_comp(longint c, longint unsigned s);
    longint unsigned m;
    m = (longint'(abs64(c)) * s) >> vnlp_pkg::FRAC;
    return c < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic proj_t project_point(longint cx, longint cy, longint cz);
    proj_t           p;
    longint          c[3];
    longint          v;
    longint unsigned ss;
    longint unsigned len;
    longint unsigned s;
    c[0] = cx;
    c[1] = cy;
    c[2] = cz;
    p.viol = 1'b0;
    if (mode_clip) begin
      for (int i = 0; i < 3; i++) begin
        v = c[i];
        if (v < -longint'(chk_lim) || v > longint'(chk_lim)) p.viol = 1'b1;
        if (v < -longint'(lim)) v = -longint'(lim);
        if (v > longint'(lim)) v = longint'(lim);
        c[i] = v;
      end
    end else begin
      ss = 0;
      for (int i = 0; i < 3; i++) ss += abs64(c[i]) * abs64(c[i]);
      if (ss > longint'(chk_lim) * longint'(chk_lim)) p.viol = 1'b1;
      if (ss > longint'(lim) * longint'(lim)) begin
        len = sqrt_floor(ss);
        s = len != 0 ? (longint'(lim) << vnlp_pkg::FRAC) / len : 0;
        for (int i = 0; i < 3; i++) c[i] = scale_comp(c[i], s);
      end
    end
    p.x = c[0][23:0];
    p.y = c[1][23:0];
    p.z = c[2][23:0];
    return p;
  endfunction

  always @(posedge clk) begin
    proj_t e;
    if (!rst_n) begin
      mode_clip  <= 1'b0;
      lim        <= '0;
      chk_lim    <= '0;
      fail_count <= 0;
      pending    <= 0;
      proj_q.delete();
    end else begin
      if (in_valid && in_ready)
        proj_q.push_back(project_point(in_comp_x, in_comp_y, in_comp_z));
      if (out_valid && out_ready) begin
        if (proj_q.size() == 0) begin
          $display("%0t unexpected transaction x=%0d y=%0d z=%0d v=%0b", $time,
                   out_proj_x, out_proj_y, out_proj_z, out_violation);
          fail_count <= fail_count + 1;
        end else begin
          e = proj_q.pop_front();
          if (e.x !== out_proj_x || e.y !== out_proj_y || e.z !== out_proj_z ||
              e.viol !== out_violation) begin
            $display("%0t mismatch exp x=%0d y=%0d z=%0d v=%0b got x=%0d y=%0d z=%0d v=%0b",
                     $time, e.x, e.y, e.z, e.viol,
                     out_proj_x, out_proj_y, out_proj_z, out_violation);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= proj_q.size();
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          vnlp_pkg::REG_CLIP_MODE:   mode_clip <= pwdata[0];
          vnlp_pkg::REG_LIMIT:       lim       <= pwdata[22:0];
          vnlp_pkg::REG_CHECK_LIMIT: chk_lim   <= pwdata[22:0];
          default: ;
        endcase
      end
    end
  end
endmodule

@@ tb/tb_vector_norm_limit_projection.sv @@
`timescale 1ns / 1ps
module tb_vector_norm_limit_projection;

  localparam int LATENCY = 48;
  localparam int MAX_CYCLES = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] in_comp_x;
  logic signed [23:0] in_comp_y;
  logic signed [23:0] in_comp_z;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] out_proj_x;
  logic signed [23:0] out_proj_y;
  logic signed [23:0] out_proj_z;
  logic               out_violation;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 phase;
  int                 hold_cycles = 0;
  logic               hold_done = 1'b0;
  int                 cycle_cnt = 0;

  vector_norm_limit_projection DUT (.*);

  vnlp_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!hold_done && phase == 2) begin
      out_ready   <= 1'b0;
      hold_cycles <= 300;
      hold_done   <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_bounds(input logic m, input logic [31:0] l, input logic [31:0] c);
    reg_write(vnlp_pkg::REG_CLIP_MODE, {31'd0, m});
    reg_write(vnlp_pkg::REG_LIMIT, l);
    reg_write(vnlp_pkg::REG_CHECK_LIMIT, c);
  endtask

  // caller is at a negedge; valid stays high on return
  task automatic send_point(input logic [23:0] x, input logic [23:0] y,
                            input logic [23:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_comp_x <= x;
    in_comp_y <= y;
    in_comp_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_comp(input logic [22:0] l);
    case ($urandom_range(5))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
      2: return 24'($signed({1'b0, l}) + $signed(24'($urandom_range(4))) - 24'sd2);
      3: return -24'($signed({1'b0, l}) + 24'sd1);
      default: return 24'($signed(24'($urandom_range(l >> 1))) - $signed(24'(l >> 2)));
    endcase
  endfunction

  initial begin
    logic [22:0] l;
    in_valid = 1'b0;
    in_comp_x = '0;
    in_comp_y = '0;
    in_comp_z = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase = -1;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero limits from reset, norm mode
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'h7fffff, 24'h800000, 24'h000001);
    drain();
    set_bounds(1'b1, 32'h0001_0000, 32'hff80_0000);
    send_point(24'h7fffff, 24'h800000, 24'h00ffff);
    send_point(24'hff0000, 24'h010000, 24'h000000);
    send_point(24'h800000, 24'h800000, 24'h800000);
    drain();
    set_bounds(1'b1, 32'h007f_ffff, 32'h0000_0000);
    send_point(24'h7fffff, 24'h800000, 24'h800001);
    send_point(24'h000000, 24'hffffff, 24'h000001);
    drain();
    set_bounds(1'b0, 32'h0003_0000, 32'h0002_0000);
    send_point(24'h030000, 24'h000000, 24'h000000);
    send_point(24'h020000, 24'h020000, 24'h010000);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_point(24'h000001, 24'hffffff, 24'h000000);
    drain();
    set_bounds(1'b0, 32'h007f_ffff, 32'h007f_ffff);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'h7fffff, 24'h000000, 24'h000000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 12; recv_idle_pct = 60; end
        1: begin send_idle_pct = 60; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: l = 23'd0;
        1: l = 23'h7fffff;
        default: l = 23'($urandom_range(23'h7fffff >> $urandom_range(22)));
      endcase
      set_bounds(1'(ph), {9'd0, l},
                 {$urandom_range(1) ? 9'd0 : 9'(1 << $urandom_range(8)),
                  23'(l + $urandom_range(8) - 4)});
      phase = ph;
      for (int k = 0; k < 84; k++)
        send_point(rand_comp(l), rand_comp(l), rand_comp(l));
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/vnlp_pkg.sv
hdl/vnlp_isqrt.sv
hdl/vnlp_div.sv
hdl/vector_norm_limit_projection.sv
tb/vnlp_checker.sv
tb/tb_vector_norm_limit_projection.sv
